@@ hdl/text_to_integer_parser_core_macros.svh @@
// ----------------------------------------------------------------------------
// text_to_integer_parser_core_macros
// assertion macros for the text to integer parser, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_INTEGER_PARSER_CORE_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TTI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/tti_pkg.sv @@
// ----------------------------------------------------------------------------
// tti_pkg
// types, character codes and helpers shared by the text to integer parser
// ----------------------------------------------------------------------------
`default_nettype none

package tti_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] UP_OFS   = 8'd55;   // 'A' - 10
    localparam logic [7:0] LO_OFS   = 8'd87;   // 'a' - 10

    localparam logic [6:0] NO_DIGIT = 7'd64;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;

    localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;
    localparam logic [63:0] NEG_CLAMP = 64'hFFFF_FFFF_8000_0000;

    localparam logic [15:0] CONSUMED_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       first;
        logic [5:0] base;
        logic       mode;
    } in_item_t;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] consumed;
        logic        digits_found;
        logic        overflowed;
    } out_item_t;

    function automatic logic [6:0] digit_value(input logic [7:0] ch);
        logic [7:0] d;
        begin
            d = {1'b0, NO_DIGIT};
            if (ch inside {[CH_ZERO:CH_NINE]})
            begin
                d = ch - CH_ZERO;
            end
            else if (ch inside {[CH_UP_A:CH_UP_Z]})
            begin
                d = ch - UP_OFS;
            end
            else if (ch inside {[CH_LO_A:CH_LO_Z]})
            begin
                d = ch - LO_OFS;
            end
            return d[6:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/tti_in_reg.sv @@
// ----------------------------------------------------------------------------
// tti_in_reg
// input register: captures one character item, frees itself when consumed
// ----------------------------------------------------------------------------
`default_nettype none

module tti_in_reg
    import tti_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     char_valid,
    output logic          char_stall,
    input  wire in_item_t char_item,
    input  wire logic     take,
    output logic          item_vld,
    output in_item_t      item
);

    logic     vld_reg;
    logic     vld_next;
    in_item_t item_reg;
    logic     load;

    // loads whenever the slot is empty or being consumed
    assign load       = !vld_reg || take;
    assign char_stall = !load;
    assign vld_next   = load ? char_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && char_valid)
        begin
            item_reg <= char_item;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

`default_nettype wire

@@ hdl/tti_parse.sv @@
// ----------------------------------------------------------------------------
// tti_parse
// parser state and one character step: prefix, sign, digit accumulate, emit
// ----------------------------------------------------------------------------
`default_nettype none

module tti_parse
    import tti_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     take,
    input  wire in_item_t item,
    output logic          emit,
    output out_item_t     res
);

    phase_t                phase_reg, phase_next;
    logic [63:0]           acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic [5:0]            base_reg, base_next;
    logic                  sgn_reg;
    logic                  any_reg, any_next;
    logic                  ovf_reg, ovf_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    // state as seen by this item, after a possible restart
    phase_t                phase_e;
    logic [63:0]           acc_e;
    logic                  neg_e;
    logic [5:0]            base_e;
    logic                  sgn_e;
    logic                  any_e;
    logic                  ovf_e;
    logic [COUNT_BITS-1:0] cnt_e;

    logic [7:0]            ch;
    logic                  dig_en;
    logic                  pre_inc;
    logic [1:0]            inc;
    logic                  hit_emit;
    logic [6:0]            d;
    logic [63:0]           prod;
    logic [63:0]           sum;
    logic [63:0]           lim;
    logic [COUNT_BITS:0]   cnt_mid_w;
    logic [COUNT_BITS-1:0] cnt_mid;
    logic [COUNT_BITS:0]   cnt_all_w;
    logic [31:0]           cnt32;
    logic                  any_mid;

    assign ch = item.char_code;

    always_comb
    begin
        if (item.first)
        begin
            phase_e = PH_LEAD;
            acc_e   = '0;
            neg_e   = 1'b0;
            base_e  = item.base;
            sgn_e   = !item.mode;
            any_e   = 1'b0;
            ovf_e   = 1'b0;
            cnt_e   = '0;
        end
        else
        begin
            phase_e = phase_reg;
            acc_e   = acc_reg;
            neg_e   = neg_reg;
            base_e  = base_reg;
            sgn_e   = sgn_reg;
            any_e   = any_reg;
            ovf_e   = ovf_reg;
            cnt_e   = cnt_reg;
        end
    end

    // phase decisions
    always_comb
    begin
        phase_next = phase_e;
        base_next  = base_e;
        neg_next   = neg_e;
        dig_en     = 1'b0;
        pre_inc    = 1'b0;
        inc        = 2'd0;
        case (phase_e)
            PH_LEAD, PH_SIGNED:
            begin
                if (phase_e == PH_LEAD && (ch == CH_SPACE || ch inside {[CH_TAB:CH_CR]}))
                begin
                    inc = 2'd1;
                end
                else if (phase_e == PH_LEAD && ((ch == CH_MINUS && sgn_e) || ch == CH_PLUS))
                begin
                    neg_next   = (ch == CH_MINUS);
                    inc        = 2'd1;
                    phase_next = PH_SIGNED;
                end
                else if ((base_e == BASE_AUTO || base_e == BASE_HEX) && ch == CH_ZERO)
                begin
                    phase_next = PH_ZERO;
                end
                else
                begin
                    base_next  = (base_e == BASE_AUTO) ? BASE_DEC : base_e;
                    phase_next = PH_DIGITS;
                    dig_en     = 1'b1;
                end
            end
            PH_ZERO:
            begin
                phase_next = PH_DIGITS;
                if (ch == CH_UP_X || ch == CH_LO_X)
                begin
                    inc       = 2'd2;
                    base_next = BASE_HEX;
                end
                else
                begin
                    // the held leading zero counts as a digit of value zero
                    base_next = (base_e == BASE_AUTO) ? BASE_OCT : base_e;
                    pre_inc   = 1'b1;
                    dig_en    = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                dig_en = 1'b1;
            end
            default:
            begin
                phase_next = phase_e;
            end
        endcase
    end

    // digit step
    assign d      = digit_value(ch);
    assign prod   = acc_e * 64'(base_next);
    assign sum    = prod + 64'(d);
    assign lim    = neg_e ? NEG_LIMIT : POS_LIMIT;
    assign any_mid = any_e || pre_inc;

    always_comb
    begin
        hit_emit = 1'b0;
        acc_next = acc_e;
        ovf_next = ovf_e;
        any_next = any_mid;
        if (dig_en)
        begin
            if (d >= {1'b0, base_next})
            begin
                hit_emit = 1'b1;
            end
            else
            begin
                any_next = 1'b1;
                if (!sgn_e)
                begin
                    acc_next = sum;
                end
                else if (!ovf_e)
                begin
                    if (sum > lim)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = sum;
                    end
                end
            end
        end
    end

    // saturating character count
    assign cnt_mid_w = {1'b0, cnt_e} + (COUNT_BITS+1)'(pre_inc);
    assign cnt_mid   = cnt_mid_w[COUNT_BITS] ? '1 : cnt_mid_w[COUNT_BITS-1:0];
    assign cnt_all_w = {1'b0, cnt_e} + (COUNT_BITS+1)'(inc)
                     + (COUNT_BITS+1)'(pre_inc)
                     + (COUNT_BITS+1)'(dig_en && !hit_emit);
    assign cnt_next  = cnt_all_w[COUNT_BITS] ? '1 : cnt_all_w[COUNT_BITS-1:0];
    assign cnt32     = 32'(cnt_mid);

    always_comb
    begin
        emit = take && hit_emit;
        if (sgn_e && ovf_e)
        begin
            res.value = neg_e ? NEG_CLAMP : POS_LIMIT;
        end
        else if (neg_e)
        begin
            res.value = 64'd0 - acc_e;
        end
        else
        begin
            res.value = acc_e;
        end
        if (!any_mid)
        begin
            res.consumed = '0;
        end
        else if (cnt32 > 32'(CONSUMED_MAX))
        begin
            res.consumed = CONSUMED_MAX;
        end
        else
        begin
            res.consumed = cnt32[15:0];
        end
        res.digits_found = any_mid;
        res.overflowed   = sgn_e && ovf_e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            base_reg  <= '0;
            sgn_reg   <= 1'b0;
            any_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= hit_emit ? PH_IDLE : phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            sgn_reg   <= sgn_e;
            any_reg   <= any_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tti_out_reg.sv @@
// ----------------------------------------------------------------------------
// tti_out_reg
// result register: holds one result item until the consumer takes it
// ----------------------------------------------------------------------------
`default_nettype none

module tti_out_reg
    import tti_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      emit,
    input  wire out_item_t res,
    output logic           can_take,
    output logic           res_valid,
    input  wire logic      res_stall,
    output out_item_t      res_item
);

    logic      vld_reg;
    logic      vld_next;
    out_item_t item_reg;

    assign can_take = !vld_reg || !res_stall;
    assign vld_next = can_take ? emit : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            item_reg <= res;
        end
    end

    assign res_valid = vld_reg;
    assign res_item  = item_reg;

endmodule

`default_nettype wire

@@ hdl/text_to_integer_parser_core.sv @@
// ----------------------------------------------------------------------------
// text_to_integer_parser_core
// streaming strtol / strtoul style parser, one character item per cycle unless stalled
//
//   channel  dir  payload     handshake
//   char     in   in_item_t   char_valid / char_stall
//   res      out  out_item_t  res_valid / res_stall
//
// one character item can be taken every cycle unless char_stall is high; the terminating
// character passes the input register, then its result is registered in the result register
// the whole step is one 64 x 6 multiply-add and limit compare per cycle
// rst_n clears all control and parser state asynchronously
// char_stall rises only while a result waits in the result register under
// res_stall and the input register is full
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_to_integer_parser_core_macros.svh"

module text_to_integer_parser_core
    import tti_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     char_valid,
    output logic          char_stall,
    input  wire in_item_t char_item,
    output logic          res_valid,
    input  wire logic     res_stall,
    output out_item_t     res_item
);

    logic      item_vld;
    in_item_t  item;
    logic      can_take;
    logic      take;
    logic      emit;
    out_item_t res;

    assign take = item_vld && can_take;

    tti_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .take       (take),
        .item_vld   (item_vld),
        .item       (item)
    );

    tti_parse #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .emit  (emit),
        .res   (res)
    );

    tti_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .res       (res),
        .can_take  (can_take),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    `TTI_ASSERT_IMP(a_stall_cause, clk, rst_n, char_stall, res_valid && res_stall,
                    "input stalled without output backpressure")
    `TTI_ASSERT_NXT(a_item_held, clk, rst_n, char_valid && !char_stall, item_vld,
                    "accepted item not registered")
    `TTI_ASSERT_IMP(a_ovf_digits, clk, rst_n, res_valid && res_item.overflowed,
                    res_item.digits_found
                    && (res_item.value == POS_LIMIT || res_item.value == NEG_CLAMP),
                    "overflow result not clamped")
    `TTI_ASSERT_IMP(a_no_digits, clk, rst_n, res_valid && !res_item.digits_found,
                    res_item.consumed == 16'd0 && res_item.value == 64'd0,
                    "empty result not zero")

endmodule

`default_nettype wire
